@@ design/sddf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sddf_pkg;

    // fixed field widths
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 4;
    localparam int POSITION_W = 4;
    localparam int CODE_W     = 4;

    // beat widths, fields packed from bit 0 and padded to whole bytes
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

    // display codes
    localparam logic [CODE_W-1:0] CODE_ZERO  = 4'd0;
    localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
    localparam logic [CODE_W-1:0] CODE_BLANK = 4'd15;

    // range limits for the out-of-range flag
    localparam logic signed [VALUE_W-1:0] LIMIT_HIGH = 32'sd99999999;
    localparam logic signed [VALUE_W-1:0] LIMIT_LOW  = -32'sd999999;

    // divide by ten: q = (n * RECIP_10) >> RECIP_SHIFT, exact for any 32-bit n
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    // what moves from one cell to the next
    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic [COUNT_W-1:0] cnt;
        logic               oor;
    } tok_t;

endpackage

`default_nettype wire

@@ design/signed_decimal_digit_formatter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Turns a signed 32-bit value and a digit count into NUM_POSITIONS digit
// writes for a display driver, position 1 (least significant) first: decimal
// digits of the magnitude within the count, a minus code (10) right after the
// digits if the value is negative and room is left, 0 at position 1 for a
// zero value, blank (15) elsewhere; counts above NUM_POSITIONS saturate.
// Every write carries an out-of-range flag (value above 99999999 or below
// -999999). Each item walks a row of NUM_POSITIONS cells, one per display
// position, each cell peeling one digit off with a reciprocal multiply and
// emitting one beat. A new item is taken in the cycle its predecessor
// leaves the last cell; output backpressure holds the token in its cell.
// An accepted item is registered in the first cell, and its first beat is
// then registered in the output register.
module signed_decimal_digit_formatter_core #(
    parameter int NUM_POSITIONS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // value [31:0], digit_count [35:32], zero [39:36]
    input  wire logic [sddf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // position [3:0], code [7:4], out_of_range [8], zero [15:9]
    output logic [sddf_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic                                    m_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready
);
    import sddf_pkg::*;

    localparam logic [NUM_POSITIONS-1:0] LAST_BIT = NUM_POSITIONS'(1) << (NUM_POSITIONS - 1);
    localparam logic [COUNT_W:0]         N_VAL    = (COUNT_W + 1)'(NUM_POSITIONS);

    logic [NUM_POSITIONS-1:0] valid;
    logic [NUM_POSITIONS-1:0] load;
    tok_t                     tok_in  [NUM_POSITIONS];
    tok_t                     tok_out [NUM_POSITIONS];
    logic [CODE_W-1:0]        code    [NUM_POSITIONS];

    logic                     adv;
    logic                     s_accept;
    tok_t                     first_tok;
    logic signed [VALUE_W-1:0] in_value;
    logic [COUNT_W-1:0]       in_count;

    logic                     m_valid_reg,  m_valid_next;
    logic [POSITION_W-1:0]    m_pos_reg,    m_pos_next;
    logic [CODE_W-1:0]        m_code_reg,   m_code_next;
    logic                     m_oor_reg,    m_oor_next;
    logic                     m_last_reg,   m_last_next;

    // output slot free this cycle
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = !(|(valid & ~LAST_BIT)) && (!(|(valid & LAST_BIT)) || adv);
    assign s_accept = s_tvalid && s_tready;

    // input beat unpacking, sign, saturation and range flag
    assign in_value = $signed(s_tdata[VALUE_W-1:0]);
    assign in_count = s_tdata[VALUE_W+COUNT_W-1:VALUE_W];

    always_comb begin
        first_tok.neg = in_value[VALUE_W-1];
        first_tok.mag = in_value[VALUE_W-1] ? (VALUE_W'(0) - s_tdata[VALUE_W-1:0])
                                            : s_tdata[VALUE_W-1:0];
        first_tok.cnt = ({1'b0, in_count} > N_VAL) ? COUNT_W'(NUM_POSITIONS) : in_count;
        first_tok.oor = (in_value > LIMIT_HIGH) || (in_value < LIMIT_LOW);
    end

    // row of cells, one per display position
    for (genvar k = 0; k < NUM_POSITIONS; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign load[k]   = s_accept;
            assign tok_in[k] = first_tok;
        end else begin : g_body
            assign load[k]   = valid[k-1] && adv;
            assign tok_in[k] = tok_out[k-1];
        end

        sddf_cell #(
            .POS (k + 1)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .load    (load[k]),
            .tok_in  (tok_in[k]),
            .adv     (adv),
            .valid   (valid[k]),
            .tok_out (tok_out[k]),
            .code    (code[k])
        );
    end

    // pick the beat of the occupied cell
    always_comb begin
        m_valid_next = m_valid_reg;
        m_pos_next   = m_pos_reg;
        m_code_next  = m_code_reg;
        m_oor_next   = m_oor_reg;
        m_last_next  = m_last_reg;
        if (adv) begin
            m_valid_next = |valid;
            for (int k = 0; k < NUM_POSITIONS; k++) begin
                if (valid[k]) begin
                    m_pos_next  = POSITION_W'(k + 1);
                    m_code_next = code[k];
                    m_oor_next  = tok_out[k].oor;
                    m_last_next = (k == NUM_POSITIONS - 1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_pos_reg  <= m_pos_next;
        m_code_reg <= m_code_next;
        m_oor_reg  <= m_oor_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W - POSITION_W - CODE_W - 1){1'b0}},
                       m_oor_reg, m_code_reg, m_pos_reg};

    // at most one item travels the row
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(valid))
        else $error("more than one cell occupied");

    // an accepted beat lands in the first cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid[0])
        else $error("accepted item missing from first cell");

    // last beat of an item is the top position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[POSITION_W-1:0] == POSITION_W'(NUM_POSITIONS)))
        else $error("last beat at wrong position");

endmodule

`default_nettype wire

@@ design/sddf_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sddf_cell #(
    parameter int POS = 1
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            load,
    input  wire sddf_pkg::tok_t                  tok_in,
    input  wire logic                            adv,
    output logic                                 valid,
    output sddf_pkg::tok_t                       tok_out,
    output logic [sddf_pkg::CODE_W-1:0]          code
);
    import sddf_pkg::*;

    localparam logic [COUNT_W:0] POS_VAL = (COUNT_W + 1)'(POS);

    logic                     valid_reg;
    logic                     valid_next;
    tok_t                     tok_reg;
    logic [2*VALUE_W-1:0]     prod;
    logic [VALUE_W-1:0]       quot;
    logic [VALUE_W-1:0]       rem_full;
    logic                     in_span;

    // token occupancy
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (adv) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload from the left neighbor
    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg <= tok_in;
        end
    end

    // one decimal digit off the magnitude
    assign prod     = tok_reg.mag * RECIP_10;
    assign quot     = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
    assign rem_full = tok_reg.mag - ((quot << 3) + (quot << 1));
    assign in_span  = ({1'b0, tok_reg.cnt} >= POS_VAL);

    // code for this position and state for the next one
    always_comb begin
        tok_out     = tok_reg;
        tok_out.mag = quot;
        code        = CODE_BLANK;
        if (in_span) begin
            if (tok_reg.mag != '0) begin
                code = rem_full[CODE_W-1:0];
            end else if (tok_reg.neg) begin
                code        = CODE_MINUS;
                tok_out.neg = 1'b0;
            end else if (POS == 1) begin
                code = CODE_ZERO;
            end else begin
                code = CODE_BLANK;
            end
        end
    end

    assign valid = valid_reg;

endmodule

`default_nettype wire
